/* rtl/cfmd_pkg.sv */
// Package for the CRC framed message deframer: payload structs, register map,
// command codes and defaults. No dependencies.
package cfmd_pkg;

   localparam int DEF_CHANNELS      = 2;
   localparam int DEF_CAPTURE_BYTES = 4;
   localparam int QUEUE_DEPTH       = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_START_BYTE = 1'b0;
   localparam logic [7:0] START_BYTE_RESET = 8'h02;

   localparam logic [7:0] CMD_RECV_LO  = 8'h11;
   localparam logic [7:0] CMD_RECV_HI  = 8'h19;
   localparam logic [7:0] CMD_SEND_LO  = 8'h91;
   localparam logic [7:0] CMD_SEND_HI  = 8'h99;
   localparam logic [7:0] CMD_REQ_A    = 8'h21;
   localparam logic [7:0] CMD_REQ_B    = 8'h22;
   localparam logic [7:0] CMD_REQ_C    = 8'h23;
   localparam logic [7:0] CMD_REQ_D    = 8'h2F;
   localparam logic [7:0] CMD_REPLY_LO = 8'hB1;
   localparam logic [7:0] CMD_REPLY_HI = 8'hB9;

   localparam logic [2:0] CLASS_APP_RECV = 3'd0;
   localparam logic [2:0] CLASS_APP_SEND = 3'd1;
   localparam logic [2:0] CLASS_APP_REQ  = 3'd2;
   localparam logic [2:0] CLASS_REPLY    = 3'd3;
   localparam logic [2:0] CLASS_OTHER    = 3'd4;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_CRC_ERR = 1'b1;

   typedef struct packed {
      logic       channel;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       out_channel;
      logic [7:0] station_id;
      logic [7:0] command;
      logic [7:0] data_length;
      logic [7:0] data_byte0;
      logic [7:0] data_byte1;
      logic [7:0] data_byte2;
      logic [7:0] data_byte3;
      logic [2:0] command_class;
      logic       frame_status;
   } rsp_type;

   // Classified byte handed from front to back.
   typedef struct packed {
      logic       channel;
      logic [7:0] rx_byte;
      logic       is_start;
   } entry_type;

endpackage

/* rtl/crc_framed_message_deframer_top.sv */
// Top level of the CRC framed message deframer: register port, front end, queues, back end.
// Depends on cfmd_pkg, cfmd_front, cfmd_fifo and cfmd_back.

// Takes one channel-tagged byte per cycle while the result queue is not full, and keeps a
// separate STX/SID/CMD/LEN/data/CRC framing state for each channel. The figure is set
// by the back end's per-channel state update, which retires one byte per cycle unless
// the result queue is full. A frame's result is pushed onto the result queue when the
// back end takes its last CRC byte from the inner queue. Both queues hold two entries;
// full rises only when the result side has stalled long enough to fill them. The start
// byte register (address 0, reset 02h) may be written only while the block is idle.
module crc_framed_message_deframer_top
   import cfmd_pkg::*;
#(
   parameter int CHANNELS      = DEF_CHANNELS,
   parameter int CAPTURE_BYTES = DEF_CAPTURE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_item,
   input  logic                  push,
   output logic                  full,
   output rsp_type               rsp_item,
   output logic                  empty,
   input  logic                  pop,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [7:0] start_byte_ff;
   logic       csr_wr;

   entry_type  q_entry_w, q_entry_r;
   logic       q_push, q_full, q_empty, q_pop;
   rsp_type    r_item;
   logic       r_push, r_full;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == REG_START_BYTE) ? {24'b0, start_byte_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
      end else if (csr_wr && paddr[2] == REG_START_BYTE) begin
         start_byte_ff <= pwdata[7:0];
      end
   end

   cfmd_front #(.CHANNELS(CHANNELS)) u_front (
      .req_item   (req_item),
      .push       (push),
      .full       (full),
      .start_byte (start_byte_ff),
      .q_push     (q_push),
      .q_entry    (q_entry_w),
      .q_full     (q_full)
   );

   cfmd_fifo #(.WIDTH($bits(entry_type)), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_entry_w),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_entry_r),
      .empty (q_empty)
   );

   cfmd_back #(.CHANNELS(CHANNELS), .CAPTURE_BYTES(CAPTURE_BYTES)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_entry (q_entry_r),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .r_push  (r_push),
      .r_item  (r_item),
      .r_full  (r_full)
   );

   cfmd_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(QUEUE_DEPTH)) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (r_push),
      .din   (r_item),
      .full  (r_full),
      .pop   (pop),
      .dout  (rsp_item),
      .empty (empty)
   );

   a_q_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("byte pushed into full inner queue");

   a_r_no_overflow: assert property (@(posedge clock) disable iff (reset)
      r_push |-> !r_full && q_pop)
      else $error("result pushed into full result queue");

   a_bad_channel_dropped: assert property (@(posedge clock) disable iff (reset)
      (push && !full && 32'(req_item.channel) >= CHANNELS) |-> !q_push)
      else $error("transaction on unconfigured channel entered the queue");

   a_result_follows_work: assert property (@(posedge clock) disable iff (reset)
      (empty && !r_push) |=> empty)
      else $error("result appeared without a finished frame");

endmodule

/* rtl/cfmd_fifo.sv */
// Small register-based FIFO used for the inner queue and the result queue.
// Depends on nothing.
module cfmd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

/* rtl/cfmd_front.sv */
// Front end: accepts received bytes, drops unconfigured channels and tags start bytes.
// Depends on cfmd_pkg.
module cfmd_front
   import cfmd_pkg::*;
#(
   parameter int CHANNELS = DEF_CHANNELS
) (
   input  req_type    req_item,
   input  logic       push,
   output logic       full,
   input  logic [7:0] start_byte,
   output logic       q_push,
   output entry_type  q_entry,
   input  logic       q_full
);

   logic ch_ok;

   assign ch_ok  = (32'(req_item.channel) < CHANNELS);
   assign full   = q_full;
   assign q_push = push && !q_full && ch_ok;

   always_comb begin
      q_entry.channel  = req_item.channel;
      q_entry.rx_byte  = req_item.rx_byte;
      q_entry.is_start = (req_item.rx_byte == start_byte);
   end

endmodule

/* rtl/cfmd_back.sv */
// Back end: per-channel framing state, running Modbus CRC-16 and result assembly.
// Depends on cfmd_pkg.
module cfmd_back
   import cfmd_pkg::*;
#(
   parameter int CHANNELS      = DEF_CHANNELS,
   parameter int CAPTURE_BYTES = DEF_CAPTURE_BYTES
) (
   input  logic      clock,
   input  logic      reset,
   input  entry_type q_entry,
   input  logic      q_empty,
   output logic      q_pop,
   output logic      r_push,
   output rsp_type   r_item,
   input  logic      r_full
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CAP_W = (CAPTURE_BYTES > 1) ? $clog2(CAPTURE_BYTES) : 1;

   typedef enum logic [2:0] {
      PH_HUNT, PH_SID, PH_CMD, PH_LEN, PH_DATA, PH_CRCH, PH_CRCL
   } phase_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [2:0] classify(input logic [7:0] c);
      logic [2:0] r;
      if (c >= CMD_RECV_LO && c <= CMD_RECV_HI) begin
         r = CLASS_APP_RECV;
      end else if (c >= CMD_SEND_LO && c <= CMD_SEND_HI) begin
         r = CLASS_APP_SEND;
      end else if (c == CMD_REQ_A || c == CMD_REQ_B || c == CMD_REQ_C || c == CMD_REQ_D) begin
         r = CLASS_APP_REQ;
      end else if (c >= CMD_REPLY_LO && c <= CMD_REPLY_HI) begin
         r = CLASS_REPLY;
      end else begin
         r = CLASS_OTHER;
      end
      return r;
   endfunction

   phase_type                       phase_ff [CHANNELS];
   logic [7:0]                      sid_ff   [CHANNELS];
   logic [7:0]                      cmd_ff   [CHANNELS];
   logic [7:0]                      len_ff   [CHANNELS];
   logic [7:0]                      cnt_ff   [CHANNELS];
   logic [15:0]                     crc_ff   [CHANNELS];
   logic [7:0]                      crch_ff  [CHANNELS];
   logic [CAPTURE_BYTES-1:0][7:0]   cap_ff   [CHANNELS];

   phase_type                     phase_in;
   logic [7:0]                    sid_in, cmd_in, len_in, cnt_in, crch_in;
   logic [15:0]                   crc_in;
   logic [CAPTURE_BYTES-1:0][7:0] cap_in;

   logic [CH_W-1:0] ch;
   logic            fire;
   logic [7:0]      b;
   logic [15:0]     crc_next;
   logic [7:0]      cnt_inc;
   logic [3:0][7:0] shown;

   assign ch       = CH_W'(q_entry.channel);
   assign b        = q_entry.rx_byte;
   assign fire     = !q_empty && !r_full;
   assign q_pop    = fire;
   assign crc_next = crc_feed(crc_ff[ch], b);
   assign cnt_inc  = cnt_ff[ch] + 8'd1;
   assign r_push   = fire && (phase_ff[ch] == PH_CRCL);

   always_comb begin
      phase_in = phase_ff[ch];
      sid_in   = sid_ff[ch];
      cmd_in   = cmd_ff[ch];
      len_in   = len_ff[ch];
      cnt_in   = cnt_ff[ch];
      crc_in   = crc_ff[ch];
      crch_in  = crch_ff[ch];
      cap_in   = cap_ff[ch];
      unique case (phase_ff[ch])
         PH_HUNT: begin
            if (q_entry.is_start) begin
               crc_in   = crc_feed(16'hFFFF, b);
               cnt_in   = '0;
               phase_in = PH_SID;
            end
         end
         PH_SID: begin
            sid_in   = b;
            crc_in   = crc_next;
            phase_in = PH_CMD;
         end
         PH_CMD: begin
            cmd_in   = b;
            crc_in   = crc_next;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            len_in   = b;
            crc_in   = crc_next;
            cnt_in   = '0;
            phase_in = (b == 8'd0) ? PH_CRCH : PH_DATA;
         end
         PH_DATA: begin
            if (32'(cnt_ff[ch]) < CAPTURE_BYTES) begin
               cap_in[cnt_ff[ch][CAP_W-1:0]] = b;
            end
            crc_in = crc_next;
            cnt_in = cnt_inc;
            if (cnt_inc >= len_ff[ch]) begin
               phase_in = PH_CRCH;
            end
         end
         PH_CRCH: begin
            crch_in  = b;
            phase_in = PH_CRCL;
         end
         PH_CRCL: begin
            phase_in = PH_HUNT;
            crc_in   = 16'hFFFF;
            cnt_in   = '0;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         shown[i] = '0;
         if (i < CAPTURE_BYTES && 32'(len_ff[ch]) > i) begin
            shown[i] = cap_ff[ch][CAP_W'(i)];
         end
      end
      r_item.out_channel   = q_entry.channel;
      r_item.station_id    = sid_ff[ch];
      r_item.command       = cmd_ff[ch];
      r_item.data_length   = len_ff[ch];
      r_item.data_byte0    = shown[0];
      r_item.data_byte1    = shown[1];
      r_item.data_byte2    = shown[2];
      r_item.data_byte3    = shown[3];
      r_item.command_class = classify(cmd_ff[ch]);
      r_item.frame_status  = ((crch_ff[ch] == crc_ff[ch][15:8]) && (b == crc_ff[ch][7:0]))
                             ? STATUS_OK : STATUS_CRC_ERR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            phase_ff[c] <= PH_HUNT;
         end
      end else if (fire) begin
         phase_ff[ch] <= phase_in;
      end
      if (fire) begin
         sid_ff[ch]  <= sid_in;
         cmd_ff[ch]  <= cmd_in;
         len_ff[ch]  <= len_in;
         cnt_ff[ch]  <= cnt_in;
         crc_ff[ch]  <= crc_in;
         crch_ff[ch] <= crch_in;
         cap_ff[ch]  <= cap_in;
      end
   end

endmodule

/* tb/crc_framed_message_deframer_checker.sv */
// Checker for the CRC framed message deframer: tracks per-channel framing, predicts each
// frame report and compares it with the result queue. Depends on cfmd_pkg.
module crc_framed_message_deframer_checker
   import cfmd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_item,
   input  logic                  push,
   input  logic                  full,
   input  rsp_type               rsp_item,
   input  logic                  empty,
   input  logic                  pop,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    failures,
   output int                    frames_checked,
   output int                    frames_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [15:0] CRC_SEED = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef enum logic [2:0] {
      HUNT, GET_SID, GET_CMD, GET_LEN, GET_DATA, GET_CRC_HI, GET_CRC_LO
   } frame_phase_type;

   frame_phase_type lane_phase  [DEF_CHANNELS];
   logic [7:0]   lane_sid    [DEF_CHANNELS];
   logic [7:0]   lane_cmd    [DEF_CHANNELS];
   logic [7:0]   lane_len    [DEF_CHANNELS];
   logic [7:0]   lane_count  [DEF_CHANNELS];
   logic [15:0]  lane_crc    [DEF_CHANNELS];
   logic [7:0]   lane_crc_hi [DEF_CHANNELS];
   logic [7:0]   lane_data   [DEF_CHANNELS][DEF_CAPTURE_BYTES];
   logic [7:0]   start_value;
   rsp_type      report_q[$];
   int           err_count;
   int           checked;

   function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic logic [2:0] class_of(logic [7:0] c);
      if (c >= CMD_RECV_LO && c <= CMD_RECV_HI) return CLASS_APP_RECV;
      if (c >= CMD_SEND_LO && c <= CMD_SEND_HI) return CLASS_APP_SEND;
      if (c == CMD_REQ_A || c == CMD_REQ_B || c == CMD_REQ_C || c == CMD_REQ_D)
         return CLASS_APP_REQ;
      if (c >= CMD_REPLY_LO && c <= CMD_REPLY_HI) return CLASS_REPLY;
      return CLASS_OTHER;
   endfunction

   task automatic clear_framers();
      start_value = START_BYTE_RESET;
      for (int ch = 0; ch < DEF_CHANNELS; ch++) begin
         lane_phase[ch]  = HUNT;
         lane_sid[ch]    = '0;
         lane_cmd[ch]    = '0;
         lane_len[ch]    = '0;
         lane_count[ch]  = '0;
         lane_crc[ch]    = CRC_SEED;
         lane_crc_hi[ch] = '0;
         for (int i = 0; i < DEF_CAPTURE_BYTES; i++) lane_data[ch][i] = '0;
      end
      report_q.delete();
   endtask

   task automatic absorb_byte(input req_type r);
      int         ch;
      logic [7:0] b;
      rsp_type    rep;
      logic [7:0] grab [4];
      ch = int'(r.channel);
      b  = r.rx_byte;
      if (ch < DEF_CHANNELS) begin
         case (lane_phase[ch])
            HUNT: begin
               if (b == start_value) begin
                  lane_crc[ch]   = crc16_update(CRC_SEED, b);
                  lane_count[ch] = '0;
                  lane_phase[ch] = GET_SID;
               end
            end
            GET_SID: begin
               lane_sid[ch]   = b;
               lane_crc[ch]   = crc16_update(lane_crc[ch], b);
               lane_phase[ch] = GET_CMD;
            end
            GET_CMD: begin
               lane_cmd[ch]   = b;
               lane_crc[ch]   = crc16_update(lane_crc[ch], b);
               lane_phase[ch] = GET_LEN;
            end
            GET_LEN: begin
               lane_len[ch]   = b;
               lane_crc[ch]   = crc16_update(lane_crc[ch], b);
               lane_count[ch] = '0;
               lane_phase[ch] = (b == 8'd0) ? GET_CRC_HI : GET_DATA;
            end
            GET_DATA: begin
               if (int'(lane_count[ch]) < DEF_CAPTURE_BYTES)
                  lane_data[ch][int'(lane_count[ch])] = b;
               lane_crc[ch]   = crc16_update(lane_crc[ch], b);
               lane_count[ch] = lane_count[ch] + 8'd1;
               if (lane_count[ch] >= lane_len[ch]) lane_phase[ch] = GET_CRC_HI;
            end
            GET_CRC_HI: begin
               lane_crc_hi[ch] = b;
               lane_phase[ch]  = GET_CRC_LO;
            end
            GET_CRC_LO: begin
               for (int i = 0; i < 4; i++)
                  grab[i] = (i < DEF_CAPTURE_BYTES && i < int'(lane_len[ch]))
                            ? lane_data[ch][i] : 8'h00;
               rep.out_channel   = r.channel;
               rep.station_id    = lane_sid[ch];
               rep.command       = lane_cmd[ch];
               rep.data_length   = lane_len[ch];
               rep.data_byte0    = grab[0];
               rep.data_byte1    = grab[1];
               rep.data_byte2    = grab[2];
               rep.data_byte3    = grab[3];
               rep.command_class = class_of(lane_cmd[ch]);
               rep.frame_status  = (lane_crc_hi[ch] == lane_crc[ch][15:8] &&
                                    b == lane_crc[ch][7:0]) ? STATUS_OK : STATUS_CRC_ERR;
               report_q.push_back(rep);
               lane_phase[ch] = HUNT;
               lane_crc[ch]   = CRC_SEED;
               lane_count[ch] = '0;
            end
            default: lane_phase[ch] = HUNT;
         endcase
      end
   endtask

   task automatic match_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         err_count++;
      end
   endtask

   task automatic check_report(input rsp_type got);
      rsp_type want;
      if (report_q.size() == 0) begin
         $error("frame report with none outstanding: %0h", got);
         err_count++;
      end else begin
         want = report_q.pop_front();
         checked++;
         match_field("out_channel", 8'(want.out_channel), 8'(got.out_channel));
         match_field("station_id", want.station_id, got.station_id);
         match_field("command", want.command, got.command);
         match_field("data_length", want.data_length, got.data_length);
         match_field("data_byte0", want.data_byte0, got.data_byte0);
         match_field("data_byte1", want.data_byte1, got.data_byte1);
         match_field("data_byte2", want.data_byte2, got.data_byte2);
         match_field("data_byte3", want.data_byte3, got.data_byte3);
         match_field("command_class", 8'(want.command_class), 8'(got.command_class));
         match_field("frame_status", 8'(want.frame_status), 8'(got.frame_status));
      end
   endtask

   initial begin
      err_count = 0;
      checked   = 0;
      clear_framers();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_framers();
      end else begin
         if (pop && !empty) check_report(rsp_item);
         if (psel && penable && pwrite && pready &&
             int'(paddr >> 2) == int'(REG_START_BYTE))
            start_value = pwdata[7:0];
         if (push && !full) absorb_byte(req_item);
      end
      failures       <= err_count;
      frames_checked <= checked;
      frames_pending <= report_q.size();
   end

endmodule

/* tb/tb_crc_framed_message_deframer_top.sv */
// Testbench top for the CRC framed message deframer: clock, reset, register writes and
// interleaved two-channel frame traffic. Depends on cfmd_pkg, the block and the checker.
module tb_crc_framed_message_deframer_top;
   import cfmd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [15:0] CRC_SEED = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [CSR_ADDR_W-1:0] START_BYTE_ADDR =
      CSR_ADDR_W'(int'(REG_START_BYTE) * 4);
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR =
      CSR_ADDR_W'((int'(REG_START_BYTE) + 1) * 4);
   localparam logic [7:0] BOUNDARY_CMDS [18] = '{
      CMD_RECV_LO - 8'd1, CMD_RECV_LO, CMD_RECV_HI, CMD_RECV_HI + 8'd1,
      CMD_SEND_LO - 8'd1, CMD_SEND_LO, CMD_SEND_HI, CMD_SEND_HI + 8'd1,
      CMD_REQ_A - 8'd1, CMD_REQ_A, CMD_REQ_B, CMD_REQ_C, CMD_REQ_C + 8'd1, CMD_REQ_D,
      CMD_REPLY_LO - 8'd1, CMD_REPLY_LO, CMD_REPLY_HI, CMD_REPLY_HI + 8'd1
   };

   typedef enum int {FLAW_NONE, FLAW_BAD_CRC, FLAW_GARBLED} frame_flaw_type;

   logic                  clock   = 1'b0;
   logic                  reset   = 1'b1;
   req_type               req_item = '0;
   logic                  push    = 1'b0;
   logic                  full;
   rsp_type               rsp_item;
   logic                  empty;
   logic                  pop     = 1'b0;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int         failures;
   int         frames_checked;
   int         frames_pending;
   int         cycle_count = 0;
   int         items_sent  = 0;
   bit         idle_on     = 1'b0;
   logic [7:0] start_setting = START_BYTE_RESET;
   logic [7:0] lane0_q[$];
   logic [7:0] lane1_q[$];

   crc_framed_message_deframer_top uut (
      .clock(clock), .reset(reset),
      .req_item(req_item), .push(push), .full(full),
      .rsp_item(rsp_item), .empty(empty), .pop(pop),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   crc_framed_message_deframer_checker checker_i (
      .clock(clock), .reset(reset),
      .req_item(req_item), .push(push), .full(full),
      .rsp_item(rsp_item), .empty(empty), .pop(pop),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .failures(failures), .frames_checked(frames_checked),
      .frames_pending(frames_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("crc_framed_message_deframer_top regression: fail");
         $finish;
      end
   end

   // result side: random stall bursts while idling is enabled
   initial begin
      int n;
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            n = $urandom_range(1, 7);
            repeat (n) @(posedge clock);
         end else begin
            pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   task automatic send_item(input logic ch, input logic [7:0] b);
      int      gap;
      req_type r;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         gap = $urandom_range(1, 7);
         repeat (gap) @(posedge clock);
      end
      r.channel = ch;
      r.rx_byte = b;
      req_item <= r;
      push     <= 1'b1;
      do @(posedge clock); while (full);
      items_sent++;
   endtask

   task automatic hold_until_drained();
      push <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr, input logic [7:0] value);
      logic [CSR_DATA_W-1:0] word;
      word       = CSR_DATA_W'($urandom());
      word[7:0]  = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_start_byte(input logic [7:0] value);
      write_register(START_BYTE_ADDR, value);
      start_setting = value;
   endtask

   task automatic queue_byte(input logic ch, input logic [7:0] b);
      if (ch) lane1_q.push_back(b);
      else lane0_q.push_back(b);
   endtask

   task automatic queue_frame(input logic ch, input logic [7:0] sid, input logic [7:0] cmd,
                              input logic [7:0] len, input frame_flaw_type flaw,
                              input int fill);
      logic [7:0]  frame[$];
      logic [15:0] crc;
      logic [7:0]  d;
      int          idx;
      frame.push_back(start_setting);
      frame.push_back(sid);
      frame.push_back(cmd);
      frame.push_back(len);
      for (int i = 0; i < int'(len); i++) begin
         if (fill >= 0) d = 8'(fill);
         else if ($urandom_range(0, 7) == 0) d = start_setting;
         else d = 8'($urandom());
         frame.push_back(d);
      end
      crc = CRC_SEED;
      foreach (frame[i]) crc = crc16_next(crc, frame[i]);
      frame.push_back(crc[15:8]);
      frame.push_back(crc[7:0]);
      if (flaw == FLAW_BAD_CRC) begin
         idx = $urandom_range(frame.size() - 2, frame.size() - 1);
         frame[idx] = frame[idx] ^ (8'd1 << $urandom_range(0, 7));
      end else if (flaw == FLAW_GARBLED) begin
         idx = $urandom_range(4, frame.size() - 1);
         for (int j = idx; j < frame.size(); j++) frame[j] = 8'($urandom());
      end
      foreach (frame[i]) queue_byte(ch, frame[i]);
   endtask

   task automatic queue_noise(input logic ch);
      int         n;
      logic [7:0] b;
      n = $urandom_range(1, 4);
      repeat (n) begin
         do b = 8'($urandom()); while (b == start_setting);
         queue_byte(ch, b);
      end
   endtask

   task automatic drain_lanes();
      logic       ch;
      logic [7:0] b;
      while (lane0_q.size() + lane1_q.size() > 0) begin
         if (lane0_q.size() == 0) ch = 1'b1;
         else if (lane1_q.size() == 0) ch = 1'b0;
         else ch = 1'($urandom_range(0, 1));
         b = ch ? lane1_q.pop_front() : lane0_q.pop_front();
         send_item(ch, b);
      end
   endtask

   task automatic random_frames(input int budget);
      int             goal;
      int             pick;
      logic           ch;
      logic [7:0]     len;
      logic [7:0]     cmd;
      frame_flaw_type flaw;
      goal = items_sent + budget;
      while (items_sent < goal) begin
         repeat ($urandom_range(1, 3)) begin
            ch   = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
               queue_noise(ch);
            end else begin
               flaw = (pick < 4) ? FLAW_BAD_CRC : (pick < 6) ? FLAW_GARBLED : FLAW_NONE;
               len  = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 6));
               cmd  = $urandom_range(0, 1) ? BOUNDARY_CMDS[$urandom_range(0, 17)]
                                           : 8'($urandom());
               queue_frame(ch, 8'($urandom()), cmd, len, flaw, -1);
            end
         end
         drain_lanes();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;

      // directed: hunt noise, empty frame, start byte as data, long frame with bad CRC
      queue_byte(1'b0, 8'hFF);
      queue_frame(1'b0, 8'h00, CMD_RECV_LO, 8'd0, FLAW_NONE, -1);
      queue_frame(1'b1, 8'hFF, CMD_REPLY_HI, 8'd1, FLAW_NONE, int'(start_setting));
      queue_frame(1'b0, 8'h5A, CMD_SEND_LO, 8'd5, FLAW_BAD_CRC, 8'hFF);
      drain_lanes();

      random_frames(300);
      hold_until_drained();
      write_register(SPARE_ADDR, 8'($urandom()));
      set_start_byte(8'h00);
      random_frames(150);
      hold_until_drained();
      random_frames(150);
      hold_until_drained();
      set_start_byte(8'hFF);
      random_frames(300);
      hold_until_drained();
      set_start_byte(8'($urandom_range(0, 255)));
      random_frames(300);
      hold_until_drained();
      set_start_byte(START_BYTE_RESET);
      idle_on = 1'b0;
      random_frames(300);
      hold_until_drained();
      repeat (8) @(posedge clock);

      $display("summary: %0d bytes pushed over two channels under five start-byte settings",
               items_sent);
      $display("summary: %0d frame reports compared, good and corrupted frames mixed",
               frames_checked);
      if (failures == 0 && frames_pending == 0) begin
         $display("crc_framed_message_deframer_top regression: pass");
      end else begin
         $display("crc_framed_message_deframer_top regression: fail");
      end
      $finish;
   end

endmodule
